// File: hw/rtl/btbd_pkg.sv
`default_nettype none

package btbd_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 4;
    // Ten BCD digits cover every 32-bit unsigned value.
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [CNT_W-1:0] DIGIT_COUNT_RESET = 4'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic check;
        logic advance;
    } btbd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cfg_zero;
        logic conv_last;
        logic pos_last;
    } btbd_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/btbd_datapath.sv
`default_nettype none

module btbd_datapath #(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [btbd_pkg::CNT_W-1:0]      cfg_wr_data,
    input  wire logic [btbd_pkg::VALUE_W-1:0]    value,
    input  wire btbd_pkg::btbd_cmd_t             cmd,
    output btbd_pkg::btbd_sts_t                  sts,
    output logic [btbd_pkg::DIGIT_W-1:0]         digit,
    output logic [btbd_pkg::POS_W-1:0]           position,
    output logic [btbd_pkg::STATUS_W-1:0]        status,
    output logic                                 last
);

    localparam logic [btbd_pkg::CNT_W-1:0] MAX_N = btbd_pkg::CNT_W'(MAX_DIGITS);
    localparam logic [btbd_pkg::BIT_CNT_W-1:0] LAST_BIT =
        btbd_pkg::BIT_CNT_W'(btbd_pkg::VALUE_W - 1);

    logic [btbd_pkg::CNT_W-1:0]     digit_count_reg;
    logic [btbd_pkg::CNT_W-1:0]     n_reg, n_next;
    logic [btbd_pkg::VALUE_W-1:0]   bin_reg, bin_next;
    logic [btbd_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic [btbd_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [btbd_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [btbd_pkg::STATUS_W-1:0]  status_reg, status_next;

    logic [btbd_pkg::BCD_W-1:0]     bcd_adj;
    logic [btbd_pkg::DIGIT_W-1:0]   digs [btbd_pkg::BCD_DIGITS];
    logic                           high_nonzero;
    logic [btbd_pkg::POS_W-1:0]     sel;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            digit_count_reg <= btbd_pkg::DIGIT_COUNT_RESET;
        end
        else if (cfg_wr_en) begin
            digit_count_reg <= cfg_wr_data;
        end
    end

    // Unpack the BCD word and apply the add-3 correction to every digit.
    always_comb begin
        high_nonzero = 1'b0;
        for (int k = 0; k < btbd_pkg::BCD_DIGITS; k++) begin
            digs[k] = bcd_reg[k*btbd_pkg::DIGIT_W +: btbd_pkg::DIGIT_W];
            bcd_adj[k*btbd_pkg::DIGIT_W +: btbd_pkg::DIGIT_W] =
                (digs[k] >= 4'd5) ? digs[k] + 4'd3 : digs[k];
            if ((btbd_pkg::CNT_W'(k) >= n_reg) && (digs[k] != '0)) begin
                high_nonzero = 1'b1;
            end
        end
    end

    always_comb begin
        n_next       = n_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        if (cmd.load) begin
            if (digit_count_reg > MAX_N) begin
                n_next = MAX_N;
            end
            else begin
                n_next = digit_count_reg;
            end
            bin_next     = value;
            bcd_next     = '0;
            bit_cnt_next = '0;
            pos_next     = '0;
            status_next  = (digit_count_reg == '0) ? btbd_pkg::STATUS_INVALID
                                                   : btbd_pkg::STATUS_OK;
        end
        if (cmd.step) begin
            bcd_next     = {bcd_adj[btbd_pkg::BCD_W-2:0], bin_reg[btbd_pkg::VALUE_W-1]};
            bin_next     = {bin_reg[btbd_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        if (cmd.check && high_nonzero) begin
            status_next = btbd_pkg::STATUS_OVERFLOW;
        end
        if (cmd.advance) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        n_reg       <= n_next;
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
    end

    assign sts.cfg_zero  = (digit_count_reg == '0);
    assign sts.conv_last = (bit_cnt_reg == LAST_BIT);
    assign sts.pos_last  = (n_reg == '0) || (pos_reg == n_reg - 1'b1);

    // Position 0 is the most significant configured digit.
    assign sel = n_reg - 1'b1 - pos_reg;

    always_comb begin
        if ((status_reg == btbd_pkg::STATUS_INVALID)
            || (sel >= btbd_pkg::POS_W'(btbd_pkg::BCD_DIGITS))) begin
            digit = '0;
        end
        else begin
            digit = digs[sel];
        end
    end

    assign position = pos_reg;
    assign status   = status_reg;
    assign last     = sts.pos_last;

endmodule

`default_nettype wire

// File: hw/rtl/btbd_controller.sv
`default_nettype none

module btbd_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire btbd_pkg::btbd_sts_t  sts,
    output btbd_pkg::btbd_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_stall = 1'b0;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.cfg_zero ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (sts.conv_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                if (!out_stall) begin
                    cmd.advance = 1'b1;
                    if (sts.pos_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/binary_to_bcd_digits.sv
// Binary to BCD digit converter.
// A request on the input channel (in_valid, in_stall, value) carries one
// 32-bit unsigned value. The block answers with a run of results on the
// output channel (out_valid, out_stall, digit, position, status, last), one
// per configured digit position, most significant position first, with last
// set on the final one. A zero digit count gives a single result with
// status invalid; a value that needs more positions than configured gives
// its low-order digits with status overflow on every result of the run.
// The digit count is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Reset loads a count of five and returns to idle.
// The conversion is a shift-add loop taking one value bit per cycle,
// followed by the overflow check; a zero count skips both. Results then
// follow one per cycle while out_stall is low.
// Only one request is in flight; in_stall stays high until the last result
// of the run has been taken. While out_stall is high the current result
// holds and nothing advances.
`default_nettype none

module binary_to_bcd_digits #(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [btbd_pkg::CNT_W-1:0]        cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [btbd_pkg::VALUE_W-1:0]      value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [btbd_pkg::DIGIT_W-1:0]           digit,
    output logic [btbd_pkg::POS_W-1:0]             position,
    output logic [btbd_pkg::STATUS_W-1:0]          status,
    output logic                                   last
);

    btbd_pkg::btbd_cmd_t cmd;
    btbd_pkg::btbd_sts_t sts;

    // The controller sequences load, conversion, check and emission.
    btbd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the count register, the shift-add converter and
    // the result selection.
    btbd_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .value       (value),
        .cmd         (cmd),
        .sts         (sts),
        .digit       (digit),
        .position    (position),
        .status      (status),
        .last        (last)
    );

    // An invalid count always produces exactly one result at position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == btbd_pkg::STATUS_INVALID)) |-> (last && (position == '0)))
        else $error("invalid result is not a single result at position zero");

    // No new request is taken while a run is being emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during result emission");

    // Within a run, positions step by one after each accepted result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=>
            (out_valid && (position == $past(position) + 4'd1)))
        else $error("result run broken or position skipped");

    // Every emitted digit is a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit <= 4'd9))
        else $error("digit out of decimal range");

endmodule

`default_nettype wire
